@@ design/ip_address_text_classifier_defines.svh @@
// Assertion macros shared by the address classifier RTL.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_DEFINES_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define IATC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define IATC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IATC_ASSERT(lbl, prop, msg)
`define IATC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/iatc_pkg.sv @@
// Package for the address text classifier: field widths, verdict codes and
// character class helpers. No dependencies.
package iatc_pkg;

   localparam int CH_W       = 8;
   localparam int VERDICT_W  = 2;
   localparam int V4_CNT_W   = 3;
   localparam int V4_LEN_W   = 2;
   localparam int V4_VAL_W   = 9;
   localparam int V6_CNT_W   = 4;
   localparam int V6_LEN_W   = 3;

   localparam logic [V4_CNT_W-1:0] V4_GROUPS     = 3'd4;
   localparam logic [V4_LEN_W-1:0] V4_LEN_SAT    = 2'd2;
   localparam logic [V4_VAL_W-1:0] V4_VAL_MAX    = 9'd255;
   localparam logic [V4_VAL_W-1:0] V4_VAL_SAT    = 9'd256;
   localparam logic [V6_CNT_W-1:0] V6_GROUPS     = 4'd8;
   localparam logic [V6_LEN_W-1:0] V6_LEN_MAX    = 3'd4;
   localparam logic [V6_LEN_W-1:0] V6_LEN_SAT    = 3'd5;

   localparam logic [CH_W-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [CH_W-1:0] CHAR_COLON = 8'h3a;
   localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NONE = 2'd0,
      VERDICT_V4   = 2'd1,
      VERDICT_V6   = 2'd2
   } verdict_type;

   function automatic logic is_dec(input logic [CH_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [CH_W-1:0] c);
      return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

endpackage

@@ design/ip_address_text_classifier.sv @@
// Address classifier top level: per-character IPv4/IPv6 tracking and verdict register.
// Depends on iatc_pkg and ip_address_text_classifier_defines.svh.
//
// Takes an address string one character per transfer (req_last marks the final
// character) and gives one verdict transfer per string: 0 neither, 1 IPv4,
// 2 IPv6. A string holding any '.' is checked only as IPv4, else one holding
// any ':' only as IPv6. One character is taken every cycle unless req_stall is
// high; the tracking state updates in the same cycle and the verdict is
// registered in the cycle after the final character. Non-final characters are
// taken even while a verdict waits on rsp_stall; a final character waits only
// until the result register frees up. State clears after each final character.
`include "ip_address_text_classifier_defines.svh"

module ip_address_text_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [iatc_pkg::CH_W-1:0]       req_ch,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [iatc_pkg::VERDICT_W-1:0]  rsp_verdict
);
   import iatc_pkg::*;

   logic                saw_dot_ff,  saw_dot_in;
   logic                saw_colon_ff, saw_colon_in;
   logic                v4_bad_ff,   v4_bad_in;
   logic [V4_CNT_W-1:0] v4_cnt_ff,   v4_cnt_in;
   logic [V4_LEN_W-1:0] v4_len_ff,   v4_len_in;
   logic                v4_lz_ff,    v4_lz_in;
   logic [V4_VAL_W-1:0] v4_val_ff,   v4_val_in;
   logic                v6_bad_ff,   v6_bad_in;
   logic [V6_CNT_W-1:0] v6_cnt_ff,   v6_cnt_in;
   logic [V6_LEN_W-1:0] v6_len_ff,   v6_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         verdict_ff,  verdict_in;

   logic                accept, accept_last;
   logic                c_dec, c_hex, c_dot, c_colon;
   logic [11:0]         v4_prod;

   // per-character results before end-of-string handling
   logic                s_dot, s_colon, s4_bad, s4_lz, s6_bad;
   logic [V4_CNT_W-1:0] s4_cnt;
   logic [V4_LEN_W-1:0] s4_len;
   logic [V4_VAL_W-1:0] s4_val;
   logic [V6_CNT_W-1:0] s6_cnt;
   logic [V6_LEN_W-1:0] s6_len;
   logic                f4_bad, f6_bad;
   logic [V4_CNT_W-1:0] f4_cnt;
   logic [V6_CNT_W-1:0] f6_cnt;

   assign req_stall   = rsp_valid_ff && rsp_stall && req_last;
   assign accept      = req_valid && !req_stall;
   assign accept_last = accept && req_last;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   assign c_dec   = is_dec(req_ch);
   assign c_hex   = is_hex(req_ch);
   assign c_dot   = (req_ch == CHAR_DOT);
   assign c_colon = (req_ch == CHAR_COLON);
   assign v4_prod = 12'(v4_val_ff) * 12'd10 + 12'(req_ch - CHAR_ZERO);

   always_comb begin
      s_dot  = saw_dot_ff;
      s4_bad = v4_bad_ff;
      s4_cnt = v4_cnt_ff;
      s4_len = v4_len_ff;
      s4_lz  = v4_lz_ff;
      s4_val = v4_val_ff;
      if (c_dot) begin
         s_dot = 1'b1;
         if (v4_len_ff == '0 || v4_val_ff > V4_VAL_MAX) s4_bad = 1'b1;
         if (v4_cnt_ff >= V4_GROUPS) s4_bad = 1'b1;
         else s4_cnt = v4_cnt_ff + 1'b1;
         s4_len = '0;
         s4_lz  = 1'b0;
         s4_val = '0;
      end else if (c_dec) begin
         if (v4_len_ff == '0) s4_lz = (req_ch == CHAR_ZERO);
         else if (v4_lz_ff) s4_bad = 1'b1;
         if (v4_len_ff < V4_LEN_SAT) s4_len = v4_len_ff + 1'b1;
         s4_val = (v4_prod > 12'(V4_VAL_SAT)) ? V4_VAL_SAT : v4_prod[V4_VAL_W-1:0];
      end else begin
         s4_bad = 1'b1;
      end
   end

   always_comb begin
      s_colon = saw_colon_ff;
      s6_bad  = v6_bad_ff;
      s6_cnt  = v6_cnt_ff;
      s6_len  = v6_len_ff;
      if (c_colon) begin
         s_colon = 1'b1;
         if (v6_len_ff == '0 || v6_len_ff > V6_LEN_MAX) s6_bad = 1'b1;
         if (v6_cnt_ff >= V6_GROUPS) s6_bad = 1'b1;
         else s6_cnt = v6_cnt_ff + 1'b1;
         s6_len = '0;
      end else if (c_hex) begin
         if (v6_len_ff < V6_LEN_SAT) s6_len = v6_len_ff + 1'b1;
      end else begin
         s6_bad = 1'b1;
      end
   end

   // end-of-string group close
   always_comb begin
      f4_bad = s4_bad || !c_dec || (s4_len == '0) || (s4_val > V4_VAL_MAX) ||
               (s4_cnt >= V4_GROUPS);
      f4_cnt = (s4_cnt >= V4_GROUPS) ? s4_cnt : s4_cnt + 1'b1;
      f6_bad = s6_bad || (s6_len == '0) || (s6_len > V6_LEN_MAX) || (s6_cnt >= V6_GROUPS);
      f6_cnt = (s6_cnt >= V6_GROUPS) ? s6_cnt : s6_cnt + 1'b1;
      verdict_in = VERDICT_NONE;
      if (s_dot) begin
         if (!f4_bad && f4_cnt == V4_GROUPS) verdict_in = VERDICT_V4;
      end else if (s_colon) begin
         if (!f6_bad && f6_cnt == V6_GROUPS) verdict_in = VERDICT_V6;
      end
   end

   always_comb begin
      saw_dot_in   = saw_dot_ff;
      saw_colon_in = saw_colon_ff;
      v4_bad_in    = v4_bad_ff;
      v4_cnt_in    = v4_cnt_ff;
      v4_len_in    = v4_len_ff;
      v4_lz_in     = v4_lz_ff;
      v4_val_in    = v4_val_ff;
      v6_bad_in    = v6_bad_ff;
      v6_cnt_in    = v6_cnt_ff;
      v6_len_in    = v6_len_ff;
      if (accept_last) begin
         saw_dot_in   = 1'b0;
         saw_colon_in = 1'b0;
         v4_bad_in    = 1'b0;
         v4_cnt_in    = '0;
         v4_len_in    = '0;
         v4_lz_in     = 1'b0;
         v4_val_in    = '0;
         v6_bad_in    = 1'b0;
         v6_cnt_in    = '0;
         v6_len_in    = '0;
      end else if (accept) begin
         saw_dot_in   = s_dot;
         saw_colon_in = s_colon;
         v4_bad_in    = s4_bad;
         v4_cnt_in    = s4_cnt;
         v4_len_in    = s4_len;
         v4_lz_in     = s4_lz;
         v4_val_in    = s4_val;
         v6_bad_in    = s6_bad;
         v6_cnt_in    = s6_cnt;
         v6_len_in    = s6_len;
      end
      rsp_valid_in = accept_last || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saw_dot_ff   <= 1'b0;
         saw_colon_ff <= 1'b0;
         v4_bad_ff    <= 1'b0;
         v4_cnt_ff    <= '0;
         v4_len_ff    <= '0;
         v4_lz_ff     <= 1'b0;
         v4_val_ff    <= '0;
         v6_bad_ff    <= 1'b0;
         v6_cnt_ff    <= '0;
         v6_len_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         saw_dot_ff   <= saw_dot_in;
         saw_colon_ff <= saw_colon_in;
         v4_bad_ff    <= v4_bad_in;
         v4_cnt_ff    <= v4_cnt_in;
         v4_len_ff    <= v4_len_in;
         v4_lz_ff     <= v4_lz_in;
         v4_val_ff    <= v4_val_in;
         v6_bad_ff    <= v6_bad_in;
         v6_cnt_ff    <= v6_cnt_in;
         v6_len_ff    <= v6_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_last) begin
         verdict_ff <= verdict_in;
      end
   end

   `IATC_ASSERT_NEXT(a_last_gives_rsp, accept_last, rsp_valid_ff, "final char without verdict")
   `IATC_ASSERT_NEXT(a_mid_no_rsp, accept && !req_last && !rsp_valid_ff, !rsp_valid_ff, "verdict from non-final char")
   `IATC_ASSERT_NEXT(a_last_clears, accept_last, !saw_dot_ff && !saw_colon_ff && v4_cnt_ff == '0 && v6_cnt_ff == '0, "state not cleared after final char")
   `IATC_ASSERT(a_counts_bounded, v4_cnt_ff <= V4_GROUPS && v6_cnt_ff <= V6_GROUPS && v4_val_ff <= V4_VAL_SAT && v6_len_ff <= V6_LEN_SAT, "tracking state out of range")

endmodule

@@ tb/tb_top.sv @@
// Testbench for ip_address_text_classifier: streams address strings one character
// per transfer and checks each verdict against an in-bench predictor.
// Depends on iatc_pkg and the classifier RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iatc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 200;
   localparam logic [CH_W-1:0] CH_NINE = "9";
   localparam logic [CH_W-1:0] CH_LA   = "a";
   localparam logic [CH_W-1:0] CH_LF   = "f";
   localparam logic [CH_W-1:0] CH_UA   = "A";
   localparam logic [CH_W-1:0] CH_UF   = "F";

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CH_W-1:0]      req_ch = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VERDICT_W-1:0] rsp_verdict;

   ip_address_text_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ch      (req_ch),
      .req_last    (req_last),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_verdict (rsp_verdict)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   bit                  saw_dot, saw_colon, v4_bad, v4_zero, v6_bad;
   logic [V4_CNT_W-1:0] v4_groups;
   logic [V4_LEN_W-1:0] v4_len;
   logic [V4_VAL_W-1:0] v4_val;
   logic [V6_CNT_W-1:0] v6_groups;
   logic [V6_LEN_W-1:0] v6_len;

   verdict_type     expected_verdicts[$];
   logic [CH_W-1:0] text[$];
   string           hex_set = "0123456789abcdefABCDEF";

   int  errors = 0;
   int  chars_sent = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_left = 0;
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  quiet_cycles = 0;
   bit  req_fire, rsp_fire;

   function automatic bit is_digit(input logic [CH_W-1:0] c);
      return c >= CHAR_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_hex_digit(input logic [CH_W-1:0] c);
      return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
   endfunction

   function automatic void clear_tracks();
      saw_dot = 0;
      saw_colon = 0;
      v4_bad = 0;
      v4_groups = '0;
      v4_len = '0;
      v4_zero = 0;
      v4_val = '0;
      v6_bad = 0;
      v6_groups = '0;
      v6_len = '0;
   endfunction

   function automatic void close_v4_group();
      if (v4_len == 0 || v4_val > V4_VAL_MAX) v4_bad = 1;
      if (v4_groups >= V4_GROUPS) v4_bad = 1;
      else v4_groups++;
      v4_len = '0;
      v4_zero = 0;
      v4_val = '0;
   endfunction

   function automatic void close_v6_group();
      if (v6_len == 0 || v6_len > V6_LEN_MAX) v6_bad = 1;
      if (v6_groups >= V6_GROUPS) v6_bad = 1;
      else v6_groups++;
      v6_len = '0;
   endfunction

   function automatic void classify_char(input logic [CH_W-1:0] c, input logic fin);
      int unsigned acc;
      verdict_type v;
      if (c == CHAR_DOT) begin
         saw_dot = 1;
         close_v4_group();
      end else if (is_digit(c)) begin
         if (v4_len == 0) v4_zero = (c == CHAR_ZERO);
         else if (v4_zero) v4_bad = 1;
         if (v4_len < V4_LEN_SAT) v4_len++;
         acc = v4_val * 10 + (c - CHAR_ZERO);
         v4_val = (acc > V4_VAL_SAT) ? V4_VAL_SAT : acc[V4_VAL_W-1:0];
      end else begin
         v4_bad = 1;
      end
      if (c == CHAR_COLON) begin
         saw_colon = 1;
         close_v6_group();
      end else if (is_hex_digit(c)) begin
         if (v6_len < V6_LEN_SAT) v6_len++;
      end else begin
         v6_bad = 1;
      end
      if (fin) begin
         if (!is_digit(c)) v4_bad = 1;
         close_v4_group();
         close_v6_group();
         v = VERDICT_NONE;
         if (saw_dot) begin
            if (!v4_bad && v4_groups == V4_GROUPS) v = VERDICT_V4;
         end else if (saw_colon) begin
            if (!v6_bad && v6_groups == V6_GROUPS) v = VERDICT_V6;
         end
         expected_verdicts.push_back(v);
         clear_tracks();
      end
   endfunction

   // string builders
   function automatic void push_dec(input int unsigned value);
      string s;
      s = $sformatf("%0d", value);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void load_text(input string s);
      text = {};
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void mutate_text();
      if ($urandom_range(15) == 0) begin
         case ($urandom_range(2))
            0: text.push_back(CHAR_DOT);
            1: text.push_back(CHAR_COLON);
            default: text.push_back(CH_W'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(15) == 0) begin
         text[$urandom_range(text.size() - 1)] = CH_W'($urandom_range(255));
      end
   endfunction

   function automatic void build_v4();
      int n_groups;
      text = {};
      n_groups = ($urandom_range(15) == 0) ? ($urandom_range(1) ? 3 : 5) : 4;
      for (int k = 0; k < n_groups; k++) begin
         if (k != 0) text.push_back(CHAR_DOT);
         case ($urandom_range(31))
            0: ;
            1: push_dec($urandom_range(256, 99999));
            2: begin
               text.push_back(CHAR_ZERO);
               push_dec($urandom_range(255));
            end
            3: push_dec(255);
            4: push_dec(0);
            5: push_dec(256);
            default: push_dec($urandom_range(255));
         endcase
      end
      mutate_text();
   endfunction

   function automatic void build_v6();
      int n_groups, n_digits;
      text = {};
      n_groups = ($urandom_range(15) == 0) ? ($urandom_range(1) ? 7 : 9) : 8;
      for (int k = 0; k < n_groups; k++) begin
         if (k != 0) text.push_back(CHAR_COLON);
         case ($urandom_range(31))
            0: n_digits = 0;
            1: n_digits = $urandom_range(5, 6);
            default: n_digits = $urandom_range(1, 4);
         endcase
         for (int d = 0; d < n_digits; d++) text.push_back(hex_set[$urandom_range(21)]);
      end
      mutate_text();
   endfunction

   function automatic void build_noise();
      int n_chars;
      text = {};
      n_chars = $urandom_range(1, 12);
      for (int i = 0; i < n_chars; i++) begin
         case ($urandom_range(3))
            0: text.push_back(CH_W'($urandom_range(255)));
            1: text.push_back($urandom_range(1) ? CHAR_DOT : CHAR_COLON);
            2: text.push_back(CH_W'(CHAR_ZERO + $urandom_range(9)));
            default: text.push_back(hex_set[$urandom_range(21)]);
         endcase
      end
   endfunction

   // sender
   task automatic send_char(input logic [CH_W-1:0] c, input logic fin);
      req_valid <= 1'b1;
      req_ch <= c;
      req_last <= fin;
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
      classify_char(c, fin);
      chars_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   // receiver
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // checker: transfers are decided by the levels held at the falling edge
   always @(negedge clock) begin
      verdict_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (rsp_fire) begin
         if (expected_verdicts.size() == 0) begin
            $error("verdict: no transfer expected, actual %0d", rsp_verdict);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_verdict !== want) begin
               $error("verdict: expected %0d, actual %0d", want, rsp_verdict);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (req_fire || rsp_fire) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // tests
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      load_text("0.0.0.0");
      send_text();
      load_text("1:2:3:4:5:6:7:8");
      send_text();
      text = {8'h00};
      send_text();
      text = {8'hff};
      send_text();
      load_text(".");
      send_text();
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct, input int n_chars);
      int target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = chars_sent + n_chars;
      while (chars_sent < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3: build_v4();
            4, 5, 6, 7: build_v6();
            default: build_noise();
         endcase
         send_text();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asks++;
      for (int i = 0; i < 12; i++) begin
         build_v4();
         send_text();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(0, 0, 400);
      test_backpressure();
      test_random(74, 0, 400);
      test_random(0, 74, 400);
      test_random(21, 21, 400);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("verdict: %0d transfers never arrived", expected_verdicts.size());
         errors++;
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
